[src/euclidean_vector_distance_assert.svh]
// assertion macros for the euclidean vector distance block
`ifndef EUCLIDEAN_VECTOR_DISTANCE_ASSERT_SVH
`define EUCLIDEAN_VECTOR_DISTANCE_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is held
`define EVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("evd assertion failed");

// checked property that also holds during reset
`define EVD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("evd assertion failed");

`else

`define EVD_ASSERT(lbl, clk, rst_n, prop)
`define EVD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[src/evd_pkg.sv]
// shared constants and types of the euclidean vector distance block
`default_nettype none

package evd_pkg;

    localparam int ELEM_W = 16;
    localparam int MAG_W  = 16;
    localparam int SQ_W   = 2 * MAG_W;
    // wide enough for 1024 squares of the largest difference
    localparam int SUM_W  = 43;
    localparam int DIST_W = 21;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // one root bit per sqrt iteration, from two bits of the sum
    localparam int SQRT_STEPS = (SUM_W + 1) / 2;
    localparam int BIT_TOP    = 2 * (SQRT_STEPS - 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_q_entry;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FIN
    } t_sqrt_state;

endpackage

`default_nettype wire

[src/evd_if.sv]
// stream interfaces for element pairs and distances
`default_nettype none

interface evd_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [evd_pkg::ELEM_W-1:0]    elem_a;
    logic signed [evd_pkg::ELEM_W-1:0]    elem_b;
    logic                                 last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface evd_dist_if;
    logic                         valid;
    logic                         ready;
    logic [evd_pkg::DIST_W-1:0]   distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

`default_nettype wire

[src/evd_front.sv]
// front end: accepts element pairs, squares differences, accumulates
`default_nettype none

module evd_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    evd_pair_if.sink                 i_pair,
    input  wire evd_pkg::t_q_status  i_q_status,
    output evd_pkg::t_q_entry        o_push
);

    localparam int RES_W = evd_pkg::Q_CNT_W + 1;

    logic signed [evd_pkg::ELEM_W:0]   diff;
    logic        [evd_pkg::ELEM_W:0]   neg_diff;
    logic        [evd_pkg::MAG_W-1:0]  mag;
    logic        [evd_pkg::SQ_W-1:0]   sq;
    logic        [evd_pkg::SUM_W:0]    sum_wide;
    logic        [evd_pkg::SUM_W-1:0]  sum_next;
    logic        [RES_W-1:0]           reserved;
    logic                              accept;

    logic                              r_sq_valid;
    logic        [evd_pkg::SQ_W-1:0]   r_sq;
    logic                              r_last;
    logic        [evd_pkg::SUM_W-1:0]  r_sum;

    always_comb begin
        diff     = {i_pair.elem_a[evd_pkg::ELEM_W-1], i_pair.elem_a}
                 - {i_pair.elem_b[evd_pkg::ELEM_W-1], i_pair.elem_b};
        neg_diff = -diff;
        mag      = diff[evd_pkg::ELEM_W] ? neg_diff[evd_pkg::MAG_W-1:0]
                                         : diff[evd_pkg::MAG_W-1:0];
        sq       = mag * mag;
    end

    // a queue slot is held for every last pair not yet pushed
    assign reserved     = RES_W'(i_q_status.count) + RES_W'(r_sq_valid & r_last);
    assign i_pair.ready = (reserved < RES_W'(evd_pkg::Q_DEPTH));
    assign accept       = i_pair.valid & i_pair.ready;

    always_comb begin
        sum_wide = {1'b0, r_sum} + (evd_pkg::SUM_W + 1)'(r_sq);
        sum_next = sum_wide[evd_pkg::SUM_W] ? evd_pkg::SUM_MAX
                                            : sum_wide[evd_pkg::SUM_W-1:0];
    end

    assign o_push.valid = r_sq_valid & r_last;
    assign o_push.sum   = sum_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_sq_valid <= accept;
            if (r_sq_valid) begin
                r_sum <= r_last ? '0 : sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq   <= sq;
            r_last <= i_pair.last;
        end
    end

endmodule

`default_nettype wire

[src/evd_queue.sv]
// short queue of finished sums between front and back
`default_nettype none

`include "euclidean_vector_distance_assert.svh"

module evd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire evd_pkg::t_q_entry  i_push,
    input  wire logic               i_pop,
    output evd_pkg::t_q_entry       o_head,
    output evd_pkg::t_q_status      o_status
);

    logic [evd_pkg::SUM_W-1:0]   r_mem [evd_pkg::Q_DEPTH];
    logic [evd_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [evd_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [evd_pkg::Q_CNT_W-1:0] r_count;
    logic                        do_pop;

    function automatic logic [evd_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [evd_pkg::Q_PTR_W-1:0] p
    );
        if (p == evd_pkg::Q_PTR_W'(evd_pkg::Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign do_pop          = i_pop & (r_count != '0);
    assign o_head.valid    = (r_count != '0);
    assign o_head.sum      = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.sum;
        end
    end

    // front reserves a slot, so a push never meets a full queue
    `EVD_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push.valid |-> (r_count < evd_pkg::Q_CNT_W'(evd_pkg::Q_DEPTH)))
    `EVD_ASSERT(a_no_empty_pop, i_clk, i_rst_n, i_pop |-> (r_count != '0))
    `EVD_ASSERT(a_count_up, i_clk, i_rst_n, (i_push.valid && !do_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

`default_nettype wire

[src/evd_back.sv]
// back end: iterative floor square root and output register
`default_nettype none

module evd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire evd_pkg::t_q_entry  i_head,
    output logic                    o_pop,
    evd_dist_if.source              o_dist
);

    evd_pkg::t_sqrt_state r_state;
    evd_pkg::t_sqrt_state n_state;

    logic                        start;
    logic                        step;
    logic                        load_out;

    logic [evd_pkg::SUM_W-1:0]   r_rem;
    logic [evd_pkg::SUM_W-1:0]   r_root;
    logic [evd_pkg::SUM_W-1:0]   r_bit;
    logic [evd_pkg::SUM_W:0]     trial;
    logic                        fits;
    logic [evd_pkg::DIST_W-1:0]  dist_sat;

    logic                        r_o_valid;
    logic [evd_pkg::DIST_W-1:0]  r_o_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        start    = 1'b0;
        step     = 1'b0;
        load_out = 1'b0;
        case (r_state)
            evd_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    start   = 1'b1;
                    n_state = evd_pkg::S_CALC;
                end
            end
            evd_pkg::S_CALC: begin
                step = 1'b1;
                if (r_bit[0]) begin
                    n_state = evd_pkg::S_FIN;
                end
            end
            evd_pkg::S_FIN: begin
                if (!r_o_valid || o_dist.ready) begin
                    load_out = 1'b1;
                    n_state  = evd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = evd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_pop = start;

    always_comb begin
        trial    = {1'b0, r_root} + {1'b0, r_bit};
        fits     = ({1'b0, r_rem} >= trial);
        dist_sat = (r_root[evd_pkg::SUM_W-1:evd_pkg::DIST_W] != '0)
                 ? evd_pkg::DIST_MAX : r_root[evd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_rem  <= i_head.sum;
            r_root <= '0;
            r_bit  <= evd_pkg::SUM_W'(1) << evd_pkg::BIT_TOP;
        end else if (step) begin
            if (fits) begin
                r_rem  <= r_rem - trial[evd_pkg::SUM_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_dist.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_dist <= dist_sat;
        end
    end

    assign o_dist.valid    = r_o_valid;
    assign o_dist.distance = r_o_dist;

endmodule

`default_nettype wire

[src/euclidean_vector_distance.sv]
// top level of the euclidean vector distance block
//
// i_pair carries one element pair a transaction: signed q8.8 elem_a and elem_b
// and a last flag on the final pair of the vectors
// o_dist carries one transaction per vector: the floor square root of the
// summed squared differences, unsigned with 8 fraction bits, saturated
// throughput: one pair per cycle while i_pair.ready is high, through the squaring
// multiplier and the 43-bit accumulate stage in the front end
// each vector end passes through the shared shift-subtract square root
// (22 iterations plus load and hand-off), so vectors that end faster than a
// root completes are paced by the sqrt unit once the two-entry sum queue fills
// path from the last pair to a valid distance: squared-difference register,
// sum queue, square root load and iterations, then the output register
// reset (synchronous, active low) clears the accumulator, the queue and the
// output valid; no clearing pass is needed
// when the receiver stalls the distance holds in the output register, the
// next root finishes and waits, the queue keeps filling, and i_pair.ready
// drops while both queue slots are taken or reserved by a pending vector end
`default_nettype none

module euclidean_vector_distance (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    evd_pair_if.sink   i_pair,
    evd_dist_if.source o_dist
);

    // front to queue: finished sums at each vector end
    evd_pkg::t_q_entry  push;
    // queue to back: oldest sum waiting for the square root
    evd_pkg::t_q_entry  head;
    // queue fill, used by the front to reserve slots
    evd_pkg::t_q_status q_status;
    logic               pop;

    evd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (i_pair),
        .i_q_status (q_status),
        .o_push     (push)
    );

    evd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    evd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_dist  (o_dist)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for the euclidean vector distance block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import evd_pkg::*;

    localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
    localparam int IDLE_PCT   = 8;
    localparam int RAND_PAIRS = 1300;
    localparam int HOLD_CYC   = 400;
    localparam int DRAIN_CYC  = 60;
    localparam int DRAIN_MAX  = 50000;
    localparam int DIR_ROWS   = 21;

    // one row of the directed table; typed rows carry a hand-read distance
    typedef struct {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     last;
        bit                       typed;
        logic [DIST_W-1:0]        exp_dist;
    } t_pair_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    evd_pair_if pair_bus ();
    evd_dist_if dist_bus ();

    euclidean_vector_distance DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_bus),
        .o_dist  (dist_bus)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: running sum of squared differences, q27.16
    logic [SUM_W-1:0]  square_acc = '0;
    logic [DIST_W-1:0] distance_q [$];

    int errors       = 0;
    int pairs_sent   = 0;
    int dists_seen   = 0;
    int longest_vec  = 0;
    int cur_vec_len  = 0;
    int tx_idle_pct  = IDLE_PCT;
    int rx_idle_pct  = IDLE_PCT;
    bit hold_req     = 1'b0;

    t_pair_row dir_rows [DIR_ROWS];

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("%0t ns  MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // floor square root, saturated to the distance field
    function automatic logic [DIST_W-1:0] floor_root_sat(logic [SUM_W-1:0] s);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 21; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= {21'd0, s})
                root = trial;
        end
        if (root > DIST_MAX)
            return DIST_MAX;
        return root[DIST_W-1:0];
    endfunction

    // add one squared difference, clamp at the top of the sum, and on the
    // final pair return the distance and clear the sum
    function automatic logic [DIST_W-1:0] accumulate_pair(
        logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b, logic last);
        logic signed [ELEM_W:0] diff;
        logic [ELEM_W:0]        mag;
        logic [SQ_W-1:0]        sq;
        logic [DIST_W-1:0]      result;
        diff = a - b;
        mag  = diff[ELEM_W] ? -diff : diff;
        sq   = mag * mag;
        if (square_acc > SUM_MAX - sq)
            square_acc = SUM_MAX;
        else
            square_acc = square_acc + sq;
        result = '0;
        if (last) begin
            result = floor_root_sat(square_acc);
            square_acc = '0;
        end
        return result;
    endfunction

    // offer one pair, with a random gap first, and book it once accepted
    task automatic send_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                             logic last, bit typed = 1'b0,
                             logic [DIST_W-1:0] typed_dist = '0);
        logic [DIST_W-1:0] want;
        while ($urandom_range(99) < tx_idle_pct) begin
            pair_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_bus.valid  <= 1'b1;
        pair_bus.elem_a <= a;
        pair_bus.elem_b <= b;
        pair_bus.last   <= last;
        @(posedge i_clk);
        while (!pair_bus.ready)
            @(posedge i_clk);
        // transaction taken at this edge
        want = accumulate_pair(a, b, last);
        pairs_sent++;
        cur_vec_len++;
        if (last) begin
            distance_q.push_back(typed ? typed_dist : want);
            if (cur_vec_len > longest_vec)
                longest_vec = cur_vec_len;
            cur_vec_len = 0;
        end
    endtask

    // mostly full-range values, some near zero, some at the rails
    function automatic logic signed [ELEM_W-1:0] pick_elem();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(9))
            6, 7: begin
                v = $urandom_range(1023);
                v = v - 16'sd512;
            end
            8: begin
                case ($urandom_range(4))
                    0: v = ELEM_MIN;
                    1: v = ELEM_MAX;
                    2: v = '0;
                    3: v = -16'sd1;
                    default: v = 16'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        dist_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                dist_bus.ready <= 1'b0;
            end else if (hold_left != 0) begin
                dist_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                // queue and output register fill, input stalls behind them
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
                dist_bus.ready <= 1'b0;
            end else begin
                dist_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // distance checker: each transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && dist_bus.valid && dist_bus.ready) begin
            if (distance_q.size() == 0) begin
                report_mismatch("distance with no vector end pending", dist_bus.distance, -1);
            end else begin
                if (dist_bus.distance !== distance_q[0])
                    report_mismatch("distance", dist_bus.distance, distance_q[0]);
                void'(distance_q.pop_front());
                dists_seen++;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int rand_pairs;
        int burst_left;
        int vec_len;
        int drain;

        pair_bus.valid  = 1'b0;
        pair_bus.elem_a = '0;
        pair_bus.elem_b = '0;
        pair_bus.last   = 1'b0;
        i_rst_n         = 1'b0;
        rand_pairs      = 0;
        burst_left      = 0;

        dir_rows = '{
            // fresh sum right after reset
            '{16'sd0,      16'sd0,      1'b1, 1'b1, 21'd0},
            '{16'sd256,    16'sd0,      1'b1, 1'b1, 21'd256},
            // largest difference both ways
            '{ELEM_MAX,    ELEM_MIN,    1'b1, 1'b1, 21'd65535},
            '{ELEM_MIN,    ELEM_MAX,    1'b1, 1'b1, 21'd65535},
            '{ELEM_MAX,    16'sd0,      1'b1, 1'b1, 21'd32767},
            '{ELEM_MIN,    16'sd0,      1'b1, 1'b1, 21'd32768},
            '{16'sd0,      ELEM_MIN,    1'b1, 1'b1, 21'd32768},
            '{ELEM_MIN,    ELEM_MIN,    1'b1, 1'b1, 21'd0},
            '{ELEM_MAX,    ELEM_MAX,    1'b1, 1'b1, 21'd0},
            // 3-4-5 triangle over two pairs, no result on the first
            '{16'sd768,    16'sd0,      1'b0, 1'b0, 21'd0},
            '{16'sd0,      16'sd1024,   1'b1, 1'b1, 21'd1280},
            '{16'sd1,      16'sd0,      1'b1, 1'b1, 21'd1},
            '{16'sd1,      16'sd0,      1'b0, 1'b0, 21'd0},
            '{16'sd0,      16'sd1,      1'b0, 1'b0, 21'd0},
            '{-16'sd1,     16'sd0,      1'b1, 1'b0, 21'd0},
            '{16'sd100,    -16'sd100,   1'b0, 1'b0, 21'd0},
            '{-16'sd5,     16'sd7,      1'b0, 1'b0, 21'd0},
            '{ELEM_MIN,    ELEM_MAX,    1'b0, 1'b0, 21'd0},
            '{16'sd0,      16'sd0,      1'b1, 1'b0, 21'd0},
            '{-16'sd1,     -16'sd1,     1'b1, 1'b1, 21'd0},
            '{16'sd12345,  -16'sd23456, 1'b1, 1'b0, 21'd0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_pair(dir_rows[r].a, dir_rows[r].b, dir_rows[r].last,
                      dir_rows[r].typed, dir_rows[r].exp_dist);

        // random vectors: mostly short, some medium, a few long
        while (rand_pairs < RAND_PAIRS) begin
            if (!hold_req && rand_pairs >= 300) begin
                hold_req   = 1'b1;
                burst_left = 80;
            end
            // quiet stretch: neither side idles
            if (rand_pairs >= 700 && rand_pairs < 1000) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (burst_left > 0)
                vec_len = $urandom_range(2, 1);
            else if ($urandom_range(99) < 70)
                vec_len = $urandom_range(8, 1);
            else if ($urandom_range(99) < 83)
                vec_len = $urandom_range(40, 9);
            else
                vec_len = $urandom_range(300, 41);
            for (int k = 0; k < vec_len; k++) begin
                send_pair(pick_elem(), pick_elem(), k == vec_len - 1);
                rand_pairs++;
                if (burst_left > 0)
                    burst_left--;
            end
        end

        // one clean vector to close
        send_pair(16'sd256, 16'sd0, 1'b1);

        pair_bus.valid <= 1'b0;

        drain = 0;
        while (distance_q.size() != 0 && drain < DRAIN_MAX) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (distance_q.size() != 0)
            report_mismatch("vector ends left unanswered", distance_q.size(), 0);

        $display("run covered %0d element pairs and %0d distances, longest vector %0d pairs",
                 pairs_sent, dists_seen, longest_vec);
        $display("including a long output hold-off, rail-to-rail differences and a no-idle stretch");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/evd_pkg.sv
src/evd_if.sv
src/evd_front.sv
src/evd_queue.sv
src/evd_back.sv
src/euclidean_vector_distance.sv
tb/sv/tb.sv
